// ===== rtl/esd_pkg.sv =====
`default_nettype none
package esd_pkg;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_A_LOWER   = 8'h61;
    localparam logic [7:0] CH_Z_LOWER   = 8'h7A;
    localparam logic [7:0] CH_A_UPPER   = 8'h41;
    localparam logic [7:0] CH_Z_UPPER   = 8'h5A;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_QUERY     = 8'h3F;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;

    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_DEL = 8'h7F;

    localparam logic [1:0] HEX_DIGITS = 2'd2;
    localparam logic [1:0] OCT_DIGITS = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
    } esd_res_t;

    typedef struct packed {
        logic [1:0] count;
        esd_res_t   res0;
        esd_res_t   res1;
    } esd_push_t;

endpackage
`default_nettype wire

// ===== rtl/esd_front.sv =====
`default_nettype none
module esd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    output esd_pkg::esd_push_t     wr
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        MODE_TEXT  = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_OCT   = 3'd3,
        MODE_CARET = 3'd4
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       is_dig, is_let;
    logic [7:0] hex_val;
    logic [7:0] hex_sum, oct_sum, num_sum;
    logic [1:0] cnt_dec;
    logic       num_ok;

    // plain-text handling of the byte
    logic       txt_emit;
    esd_res_t   txt_res;
    mode_t      txt_mode;

    assign is_dig  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_let  = ((in_byte >= CH_A_UPPER) && (in_byte <= CH_Z_UPPER))
                  || ((in_byte >= CH_A_LOWER) && (in_byte <= CH_Z_LOWER));
    assign hex_val = is_dig ? (in_byte - CH_ZERO) : (in_byte - CH_A_LOWER + 8'd10);
    assign hex_sum = {acc_reg[3:0], 4'b0000} + hex_val;
    assign oct_sum = {acc_reg[4:0], 3'b000} + (in_byte - CH_ZERO);
    assign cnt_dec = cnt_reg - 2'd1;
    assign num_sum = (mode_reg == MODE_HEX) ? hex_sum : oct_sum;
    assign num_ok  = (cnt_reg != 2'd0)
                  && ((mode_reg == MODE_HEX) ? (is_dig || is_let) : is_dig);

    always_comb
    begin
        txt_emit = 1'b0;
        txt_res  = '{out_byte: in_byte, end_of_string: 1'b0};
        txt_mode = MODE_TEXT;
        priority if (in_byte == CH_NUL)
        begin
            txt_emit = 1'b1;
            txt_res  = '{out_byte: CH_NUL, end_of_string: 1'b1};
        end
        else if (in_byte == CH_BACKSLASH)
            txt_mode = MODE_ESC;
        else if (in_byte == CH_CARET)
            txt_mode = MODE_CARET;
        else
            txt_emit = 1'b1;
    end

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        wr.count  = 2'd0;
        wr.res0   = '{out_byte: in_byte, end_of_string: 1'b0};
        wr.res1   = txt_res;
        unique case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_TEXT;
                wr.count  = 2'd1;
                priority if (in_byte == CH_NUL)
                begin
                    wr.res0  = '{out_byte: CH_NUL, end_of_string: 1'b1};
                    acc_next = 8'd0;
                    cnt_next = 2'd0;
                end
                else if (in_byte == CH_N)
                    wr.res0.out_byte = CODE_LF;
                else if (in_byte == CH_R)
                    wr.res0.out_byte = CODE_CR;
                else if (in_byte == CH_T)
                    wr.res0.out_byte = CODE_TAB;
                else if (in_byte == CH_B)
                    wr.res0.out_byte = CODE_BS;
                else if (in_byte == CH_X)
                begin
                    wr.count  = 2'd0;
                    mode_next = MODE_HEX;
                    acc_next  = 8'd0;
                    cnt_next  = HEX_DIGITS;
                end
                else if (in_byte == CH_ZERO)
                begin
                    wr.count  = 2'd0;
                    mode_next = MODE_OCT;
                    acc_next  = 8'd0;
                    cnt_next  = OCT_DIGITS;
                end
            end
            MODE_HEX, MODE_OCT:
            begin
                if (num_ok)
                begin
                    if (cnt_dec != 2'd0)
                    begin
                        acc_next = num_sum;
                        cnt_next = cnt_dec;
                    end
                    else
                    begin
                        wr.count  = 2'd1;
                        wr.res0   = '{out_byte: num_sum, end_of_string: 1'b0};
                        mode_next = MODE_TEXT;
                        acc_next  = 8'd0;
                        cnt_next  = 2'd0;
                    end
                end
                else
                begin
                    // terminating byte goes on as plain text
                    wr.count  = txt_emit ? 2'd2 : 2'd1;
                    wr.res0   = '{out_byte: acc_reg, end_of_string: 1'b0};
                    wr.res1   = txt_res;
                    mode_next = txt_mode;
                    acc_next  = 8'd0;
                    cnt_next  = 2'd0;
                end
            end
            MODE_CARET:
            begin
                wr.count  = 2'd1;
                mode_next = MODE_TEXT;
                acc_next  = 8'd0;
                cnt_next  = 2'd0;
                priority if (in_byte == CH_NUL)
                    wr.res0 = '{out_byte: CH_NUL, end_of_string: 1'b1};
                else if (in_byte == CH_QUERY)
                    wr.res0.out_byte = CODE_DEL;
                else
                    wr.res0.out_byte = in_byte - CH_AT;
            end
            default:
            begin
                wr.count  = txt_emit ? 2'd1 : 2'd0;
                wr.res0   = txt_res;
                mode_next = txt_mode;
                if (in_byte == CH_NUL)
                begin
                    acc_next = 8'd0;
                    cnt_next = 2'd0;
                end
            end
        endcase
        if (!accept)
            wr.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            acc_reg  <= 8'd0;
            cnt_reg  <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/esd_queue.sv =====
`default_nettype none
module esd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire esd_pkg::esd_push_t wr,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output esd_pkg::esd_res_t      rd
);
    import esd_pkg::*;

    esd_res_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QPTR_W-1:0]   wptr_1;
    logic                do_pop;

    assign wptr_1 = wptr_reg + QPTR_W'(1);
    assign do_pop = pop && !empty;
    assign empty  = (cnt_reg == '0);
    // room for a full two-result transaction
    assign full   = (cnt_reg > QCNT_W'(QUEUE_DEPTH - 2));
    assign rd     = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
            mem[wptr_reg] <= wr.res0;
        if (wr.count == 2'd2)
            mem[wptr_1] <= wr.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + QPTR_W'(wr.count);
            if (do_pop)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg + QCNT_W'(wr.count) - QCNT_W'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/escape_sequence_decoder.sv =====
// Escape sequence decoder.
// Input channel: push/full. A byte is taken at a clock edge with push high
// and full low; a zero byte ends the string.
// Output channel: empty/pop. While empty is low, out_byte/end_of_string show
// the oldest decoded byte; it is consumed at an edge with pop high.
// Each input transaction yields zero, one or two output transactions (a
// number cut short by a non-digit gives it, then parses that byte as text).
// A result is queued at the edge that takes the byte that completes it.
// Throughput: one input byte per cycle while full is low, set by the parser.
// The parser feeds a 4-entry result queue; full rises when fewer than two
// entries are free, so a stalled receiver holds off input once three or
// more results are pending, and nothing is lost.
// Reset clears the parse state and empties the queue; the first byte may
// be pushed in the cycle after reset is released.
`default_nettype none
module escape_sequence_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            end_of_string
);
    import esd_pkg::*;

    esd_push_t wr;
    esd_res_t  rd;
    logic      accept;

    assign accept = push && !full;

    esd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .wr      (wr)
    );

    esd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .rd    (rd)
    );

    assign out_byte      = rd.out_byte;
    assign end_of_string = rd.end_of_string;

endmodule
`default_nettype wire

// ===== tb/escape_sequence_decoder_tb.sv =====
`timescale 1ns / 100ps
module escape_sequence_decoder_tb;
    import esd_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT,
        MODE_CARET
    } parse_mode_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       end_of_string;
    } decoded_t;

    typedef logic [7:0] byte_seq_t[$];

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       end_of_string;

    decoded_t    pending_bytes[$];
    parse_mode_t mode_q;
    logic [7:0]  number_acc;
    logic [1:0]  digits_left;

    int mismatch_count = 0;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 0;

    escape_sequence_decoder DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_byte(in_byte),
        .empty(empty),
        .pop(pop),
        .out_byte(out_byte),
        .end_of_string(end_of_string)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** escape_sequence_decoder: FAILED **");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= CH_A_UPPER && c <= CH_Z_UPPER) || (c >= CH_A_LOWER && c <= CH_Z_LOWER);
    endfunction

    task automatic emit(input logic [7:0] b, input logic eos);
        decoded_t d;
        d.out_byte = b;
        d.end_of_string = eos;
        pending_bytes.push_back(d);
    endtask

    task automatic clear_parse();
        mode_q = MODE_TEXT;
        number_acc = 8'h00;
        digits_left = 2'd0;
    endtask

    task automatic plain_text(input logic [7:0] c);
        if (c == CH_NUL)
        begin
            clear_parse();
            emit(CH_NUL, 1'b1);
        end
        else if (c == CH_BACKSLASH)
            mode_q = MODE_ESC;
        else if (c == CH_CARET)
            mode_q = MODE_CARET;
        else
            emit(c, 1'b0);
    endtask

    task automatic decode_byte(input logic [7:0] c);
        logic       take;
        logic [7:0] digit;
        case (mode_q)
            MODE_ESC:
            begin
                mode_q = MODE_TEXT;
                case (c)
                    CH_NUL:
                    begin
                        clear_parse();
                        emit(CH_NUL, 1'b1);
                    end
                    CH_N: emit(CODE_LF, 1'b0);
                    CH_R: emit(CODE_CR, 1'b0);
                    CH_T: emit(CODE_TAB, 1'b0);
                    CH_B: emit(CODE_BS, 1'b0);
                    CH_X:
                    begin
                        mode_q = MODE_HEX;
                        number_acc = 8'h00;
                        digits_left = HEX_DIGITS;
                    end
                    CH_ZERO:
                    begin
                        mode_q = MODE_OCT;
                        number_acc = 8'h00;
                        digits_left = OCT_DIGITS;
                    end
                    default: emit(c, 1'b0);
                endcase
            end
            MODE_HEX, MODE_OCT:
            begin
                take = digits_left != 2'd0
                       && (is_dec(c) || (mode_q == MODE_HEX && is_alpha(c)));
                if (take)
                begin
                    // letters of either case count from 'a', wrapped to 8 bits
                    if (is_dec(c))
                        digit = c - CH_ZERO;
                    else
                        digit = c - CH_A_LOWER + 8'd10;
                    if (mode_q == MODE_HEX)
                        number_acc = {number_acc[3:0], 4'h0} + digit;
                    else
                        number_acc = {number_acc[4:0], 3'b000} + digit;
                    digits_left = digits_left - 2'd1;
                    if (digits_left == 2'd0)
                    begin
                        emit(number_acc, 1'b0);
                        clear_parse();
                    end
                end
                else
                begin
                    emit(number_acc, 1'b0);
                    clear_parse();
                    plain_text(c);
                end
            end
            MODE_CARET:
            begin
                clear_parse();
                if (c == CH_NUL)
                    emit(CH_NUL, 1'b1);
                else if (c == CH_QUERY)
                    emit(CODE_DEL, 1'b0);
                else
                    emit(c - CH_AT, 1'b0);
            end
            default:
            begin
                mode_q = MODE_TEXT;
                plain_text(c);
            end
        endcase
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected transaction out_byte=%h eos=%b",
                                          out_byte, end_of_string));
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.out_byte));
                if (end_of_string !== want.end_of_string)
                    report_mismatch($sformatf("end_of_string %b, want %b (out_byte %h)",
                                              end_of_string, want.end_of_string,
                                              want.out_byte));
            end
        end
    end

    // ---------------- receiver ----------------

    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_byte <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        decode_byte(c);
        bytes_sent++;
    endtask

    task automatic send_seq(input byte_seq_t seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_BACKSLASH || c == CH_CARET);
        return c;
    endfunction

    function automatic logic [7:0] alnum_char();
        case ($urandom_range(2))
            0: return CH_ZERO + 8'($urandom_range(9));
            1: return CH_A_LOWER + 8'($urandom_range(25));
            default: return CH_A_UPPER + 8'($urandom_range(25));
        endcase
    endfunction

    task automatic send_random_token();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 30)
            send_byte(plain_char());
        else if (kind < 40)
        begin
            send_byte(CH_BACKSLASH);
            case ($urandom_range(4))
                0: send_byte(CH_N);
                1: send_byte(CH_R);
                2: send_byte(CH_T);
                3: send_byte(CH_B);
                default: send_byte(8'($urandom_range(255)));
            endcase
        end
        else if (kind < 58)
        begin
            send_seq('{CH_BACKSLASH, CH_X});
            n = $urandom_range(2);
            repeat (n) send_byte(alnum_char());
        end
        else if (kind < 75)
        begin
            send_seq('{CH_BACKSLASH, CH_ZERO});
            n = $urandom_range(2);
            repeat (n) send_byte(CH_ZERO + 8'($urandom_range(9)));
        end
        else if (kind < 85)
        begin
            send_byte(CH_CARET);
            if ($urandom_range(9) == 0)
                send_byte(CH_QUERY);
            else
                send_byte(8'($urandom_range(255)));
        end
        else if (kind < 93)
            send_byte(8'($urandom_range(255)));
        else
            send_byte(CH_NUL);
    endtask

    // ---------------- tests ----------------

    task automatic test_control_escapes();
        send_seq('{CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_R, CH_BACKSLASH, CH_T,
                   CH_BACKSLASH, CH_B, CH_BACKSLASH, 8'hFF});
    endtask

    task automatic test_numbers();
        // hex with upper and lower case letters, full after two digits
        send_seq('{CH_BACKSLASH, CH_X, 8'h46, 8'h66});
        // hex cut short by a non-digit: number then the byte
        send_seq('{CH_BACKSLASH, CH_X, 8'h37, 8'h21});
        // pending octal number flushed by the terminator
        send_seq('{CH_BACKSLASH, CH_ZERO, 8'h31, CH_NUL});
    endtask

    task automatic test_caret_and_terminator();
        send_seq('{CH_CARET, CH_QUERY, CH_CARET, CH_NUL, CH_BACKSLASH, CH_NUL});
    endtask

    task automatic test_random_strings(input int count, input int s_pct, input int r_pct);
        int stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_token();
        send_byte(CH_NUL);
    endtask

    task automatic test_input_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1;
        repeat (60) send_byte(plain_char());
        send_byte(CH_NUL);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        in_byte <= 8'h00;
        clear_parse();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_control_escapes();
        test_numbers();
        test_caret_and_terminator();
        test_random_strings(470, 22, 77);
        test_random_strings(470, 77, 22);
        test_random_strings(470, 0, 0);
        test_input_stall();

        push <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** escape_sequence_decoder: PASSED **");
        else
            $display("** escape_sequence_decoder: FAILED **");
        $finish;
    end

endmodule
